// ===== rtl/tpa_pkg.sv =====
// Package for the tagged page allocator: sizes, status codes and shared types.
// Used by every module under rtl.
package tpa_pkg;
  localparam int NUM_PAGES = 256;
  localparam int MAX_TAGS = 16;
  localparam int PW = $clog2(NUM_PAGES);
  localparam int CW = $clog2(NUM_PAGES + 1);
  localparam int TW = $clog2(MAX_TAGS);
  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_NO_PAGE = 2'd1,
    ST_TAG_FULL = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic        mode;
    logic [63:0] tag;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  page_index;
    logic [27:0] page_base;
    logic [8:0]  pages_freed;
  } rsp_t;
endpackage

// ===== rtl/tpa_front.sv =====
// Front part: input handshake, request unpack and a short request queue.
// Depends on tpa_pkg.
module tpa_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [64:0]   in_tdata,
  output logic          q_valid,
  input  logic          q_ready,
  output tpa_pkg::req_t q_req
);
  import tpa_pkg::*;

  req_t                    mem_r [QDEPTH];
  logic [$clog2(QDEPTH):0] cnt_r, cnt_nxt;
  logic [$clog2(QDEPTH)-1:0] wp_r, rp_r;
  logic push, pop;

  assign in_tready = (cnt_r != QDEPTH[$clog2(QDEPTH):0]);
  assign q_valid = (cnt_r != '0);
  assign q_req = mem_r[rp_r];
  assign push = in_tvalid && in_tready;
  assign pop = q_valid && q_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r].mode <= in_tdata[0];
      mem_r[wp_r].tag <= in_tdata[64:1];
    end
  end
endmodule

// ===== rtl/tpa_back.sv =====
// Back part: tag lookup, page allocation, chain walk and result register.
// Depends on tpa_pkg.
module tpa_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  tpa_pkg::req_t q_req,
  input  logic [20:0]   page_size,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [47:0]   out_tdata
);
  import tpa_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOOK  = 6'b000010,
    S_FRD   = 6'b000100,
    S_MUL   = 6'b001000,
    S_WALK  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r;
  req_t   req_r;
  logic   tag_valid_r [MAX_TAGS];
  logic [63:0] tag_key_r [MAX_TAGS];
  logic [PW-1:0] head_r [MAX_TAGS];
  logic [PW-1:0] tail_r [MAX_TAGS];
  logic [PW-1:0] link_mem [NUM_PAGES];
  logic [PW-1:0] fifo_mem [NUM_PAGES];
  logic [PW-1:0] rd_ptr_r, wr_ptr_r;
  logic [CW-1:0] fifo_cnt_r, fresh_r, freed_r;
  logic [TW-1:0] slot_r;
  logic          hit_r;
  logic [PW-1:0] page_r, walk_r, link_q, fifo_q;
  logic [PW-1:0] link_ra;
  rsp_t          rsp_r;

  logic          hit_c, empty_c;
  logic [TW-1:0] hit_idx_c, empty_idx_c;

  always_comb begin
    hit_c = 1'b0;
    empty_c = 1'b0;
    hit_idx_c = '0;
    empty_idx_c = '0;
    for (int i = MAX_TAGS - 1; i >= 0; i--) begin
      if (tag_valid_r[i] && tag_key_r[i] == req_r.tag) begin
        hit_c = 1'b1;
        hit_idx_c = TW'(i);
      end
      if (!tag_valid_r[i]) begin
        empty_c = 1'b1;
        empty_idx_c = TW'(i);
      end
    end
  end

  assign q_ready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata = {1'b0, rsp_r.pages_freed, rsp_r.page_base, rsp_r.page_index,
                      rsp_r.status};
  assign link_ra = (state_r == S_LOOK) ? head_r[hit_idx_c] : link_q;

  always_ff @(posedge clk) begin
    link_q <= link_mem[link_ra];
    fifo_q <= fifo_mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      fifo_cnt_r <= '0;
      fresh_r <= '0;
      for (int i = 0; i < MAX_TAGS; i++) tag_valid_r[i] <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            req_r <= q_req;
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          rsp_r.page_index <= '0;
          rsp_r.page_base <= '0;
          rsp_r.pages_freed <= '0;
          hit_r <= hit_c;
          slot_r <= hit_c ? hit_idx_c : empty_idx_c;
          if (req_r.mode) begin
            if (!hit_c) begin
              rsp_r.status <= ST_NOT_FOUND;
              state_r <= S_OUT;
            end else begin
              rsp_r.status <= ST_OK;
              walk_r <= head_r[hit_idx_c];
              freed_r <= '0;
              state_r <= S_WALK;
            end
          end else if (fifo_cnt_r == '0 && fresh_r == CW'(NUM_PAGES)) begin
            rsp_r.status <= ST_NO_PAGE;
            state_r <= S_OUT;
          end else if (!hit_c && !empty_c) begin
            rsp_r.status <= ST_TAG_FULL;
            state_r <= S_OUT;
          end else begin
            rsp_r.status <= ST_OK;
            state_r <= S_FRD;
          end
        end
        S_FRD: begin
          if (fifo_cnt_r != '0) begin
            page_r <= fifo_q;
            rd_ptr_r <= rd_ptr_r + 1'b1;
            fifo_cnt_r <= fifo_cnt_r - 1'b1;
          end else begin
            page_r <= fresh_r[PW-1:0];
            fresh_r <= fresh_r + 1'b1;
          end
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (!hit_r) begin
            tag_valid_r[slot_r] <= 1'b1;
            tag_key_r[slot_r] <= req_r.tag;
            head_r[slot_r] <= page_r;
          end
          tail_r[slot_r] <= page_r;
          rsp_r.page_index <= 8'(page_r);
          rsp_r.page_base <= 28'(page_r * page_size);
          state_r <= S_OUT;
        end
        S_WALK: begin
          fifo_mem[wr_ptr_r] <= walk_r;
          wr_ptr_r <= wr_ptr_r + 1'b1;
          fifo_cnt_r <= fifo_cnt_r + 1'b1;
          freed_r <= freed_r + 1'b1;
          if (walk_r == tail_r[slot_r]) begin
            tag_valid_r[slot_r] <= 1'b0;
            rsp_r.pages_freed <= 9'(freed_r + 1'b1);
            state_r <= S_OUT;
          end else begin
            walk_r <= link_q;
          end
        end
        S_OUT: begin
          if (out_tready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MUL && hit_r) link_mem[tail_r[slot_r]] <= page_r;
  end
endmodule

// ===== rtl/tagged_page_allocator_core.sv =====
// Tagged page allocator: allocate pages for 64-bit tags, free all by tag.
// Channels: in_* requests (tdata = mode, tag), out_* results
// (tdata = status, page_index, page_base, pages_freed), cfg_* page size.
// A two-entry queue decouples request intake from the allocation engine.
// Allocate steps from queue head to result: dequeue, lookup, page pick,
// multiply and commit, output. Free-all steps: dequeue, lookup, a walk over
// the link memory that frees each page in the chain, then output.
// One request is in the engine at a time; the queue takes up to two more.
// Result holds on out_tdata until out_tready; the engine waits meanwhile.
// Reset empties the queue, clears all tags and the free FIFO, and sets
// page_size to 4096. cfg_ready is always high.
module tagged_page_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [0] mode, [64:1] tag
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [1:0] status, [9:2] page_index, [37:10] page_base, [46:38] pages_freed
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [20:0] cfg_data
);
  import tpa_pkg::*;

  logic        q_valid, q_ready;
  req_t        q_req;
  logic [20:0] page_size_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) page_size_r <= 21'd4096;
    else if (cfg_valid) page_size_r <= cfg_data;
  end

  tpa_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .in_tdata(in_tdata[64:0]), .q_valid, .q_ready, .q_req
  );

  tpa_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_req,
    .page_size(page_size_r), .out_tvalid, .out_tready, .out_tdata
  );
endmodule

// ===== rtl/tpa_checker.sv =====
// Port-level checker for the tagged page allocator, bound to the top level.
// Depends on tpa_pkg.
module tpa_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);
  import tpa_pkg::*;

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ST_OK |-> out_tdata[37:2] == '0)
    else $error("error result carries page");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[46:38] != '0 |-> out_tdata[9:2] == '0)
    else $error("free result carries page index");
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result after reset");
endmodule

bind tagged_page_allocator_core tpa_port_checker u_chk (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata
);
